// ----- src/x86_64_subset_decode_execute_top_assert.svh -----
// Assertion macros for the x86-64 subset decode/execute block.
// Used by x86_64_subset_decode_execute_top; no other dependencies.
`ifndef X86_64_SUBSET_DECODE_EXECUTE_TOP_ASSERT_SVH
`define X86_64_SUBSET_DECODE_EXECUTE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define X86SS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define X86SS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define X86SS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define X86SS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/x86ss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the x86-64 subset decode/execute block.
// No dependencies.
package x86ss_pkg;

   localparam int FetchWindowBytes = 8;
   localparam int ReqDataW         = 208;
   localparam int ReqUserW         = 2;
   localparam int RspDataW         = 144;

   typedef enum logic [1:0] {
      CMD_EXEC  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FETCH   = 3'd1,
      ST_NOTIMPL = 3'd2,
      ST_UNDEC   = 3'd3,
      ST_STACK   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_ENDBR  = 3'd1,
      KIND_XOR    = 3'd2,
      KIND_AND    = 3'd3,
      KIND_MOV    = 3'd4,
      KIND_POP    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OPS_32 = 2'd0,
      OPS_16 = 2'd1,
      OPS_64 = 2'd2
   } opsize_type;

   localparam logic [4:0]  SEL_RIP      = 5'd16;
   localparam logic [4:0]  SEL_FLAGS    = 5'd17;
   localparam logic [3:0]  RSP_IDX      = 4'd4;

   localparam logic [31:0] ENDBR64_CODE = 32'hfa1e0ff3;
   localparam logic [7:0]  OPC_PFX66    = 8'h66;
   localparam logic [3:0]  REX_HI       = 4'h4;
   localparam logic [7:0]  OPC_XOR      = 8'h31;
   localparam logic [7:0]  OPC_AND      = 8'h83;
   localparam logic [7:0]  OPC_MOV      = 8'h89;
   localparam logic [7:0]  OPC_POP      = 8'h58;
   localparam logic [2:0]  AND_EXT      = 3'd4;
   localparam logic [1:0]  MOD_REG      = 2'b11;

   typedef struct packed {
      status_type status;
      kind_type   kind;
      logic [3:0] len;
      opsize_type size;
      logic [3:0] rmf;    // r/m register, or POP destination
      logic [3:0] regf;
      logic [7:0] imm;
   } dec_type;

endpackage

// ----- src/x86ss_decode.sv -----
`timescale 1ns / 1ps
// Instruction decoder: prefixes, opcode, ModRM, length and early status.
// Depends on x86ss_pkg.
module x86ss_decode #(
   parameter int FETCH_WINDOW_BYTES = x86ss_pkg::FetchWindowBytes
) (
   input  logic [63:0]        fetch_bytes,
   input  logic [3:0]         fetch_count,
   input  logic               stack_ok,
   output x86ss_pkg::dec_type dec
);

   localparam logic [3:0] WinBytes = 4'(FETCH_WINDOW_BYTES);

   function automatic logic [7:0] byte_at(input logic [63:0] fb, input logic [4:0] idx);
      byte_at = (idx < 5'd8) ? fb[{idx[2:0], 3'b000} +: 8] : 8'h00;
   endfunction

   logic [3:0] avail;
   logic [4:0] avail5;
   logic [7:0] is_pfx;
   logic [3:0] off;
   logic [4:0] off1;
   logic [4:0] off2;
   logic [7:0] rex;
   logic       p66;
   logic [7:0] opc;
   logic [7:0] modrm;

   always_comb begin
      avail  = (fetch_count > WinBytes) ? WinBytes : fetch_count;
      avail5 = {1'b0, avail};
      for (int i = 0; i < 8; i++) begin
         is_pfx[i] = (fetch_bytes[8*i +: 8] == x86ss_pkg::OPC_PFX66) ||
                     (fetch_bytes[8*i+4 +: 4] == x86ss_pkg::REX_HI);
      end
      // first non-prefix byte; bytes past the 8-byte word read as zero
      off = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (!is_pfx[i]) begin
            off = 4'(i);
         end
      end
      // 0x66 anywhere in the run; last REX wins
      rex = 8'h00;
      p66 = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < off) begin
            if (fetch_bytes[8*i +: 8] == x86ss_pkg::OPC_PFX66) begin
               p66 = 1'b1;
            end else begin
               rex = fetch_bytes[8*i +: 8];
            end
         end
      end
      off1  = {1'b0, off} + 5'd1;
      off2  = {1'b0, off} + 5'd2;
      opc   = byte_at(fetch_bytes, {1'b0, off});
      modrm = byte_at(fetch_bytes, off1);

      dec.status = x86ss_pkg::ST_OK;
      dec.kind   = x86ss_pkg::KIND_NONE;
      dec.len    = 4'd0;
      dec.size   = rex[3] ? x86ss_pkg::OPS_64 : (p66 ? x86ss_pkg::OPS_16 : x86ss_pkg::OPS_32);
      dec.rmf    = {rex[0], modrm[2:0]};
      dec.regf   = {rex[2], modrm[5:3]};
      dec.imm    = byte_at(fetch_bytes, off2);

      if (avail < 4'd4) begin
         dec.status = x86ss_pkg::ST_FETCH;
      end else if (fetch_bytes[31:0] == x86ss_pkg::ENDBR64_CODE) begin
         dec.kind = x86ss_pkg::KIND_ENDBR;
         dec.len  = 4'd4;
      end else if (off >= avail) begin
         dec.status = x86ss_pkg::ST_FETCH;
      end else if (opc == x86ss_pkg::OPC_XOR || opc == x86ss_pkg::OPC_AND ||
                   (opc == x86ss_pkg::OPC_MOV && rex[3])) begin
         if (off1 >= avail5) begin
            dec.status = x86ss_pkg::ST_FETCH;
         end else if (opc == x86ss_pkg::OPC_AND && modrm[5:3] != x86ss_pkg::AND_EXT) begin
            dec.status = x86ss_pkg::ST_NOTIMPL;
         end else if (opc == x86ss_pkg::OPC_AND && off2 >= avail5) begin
            dec.status = x86ss_pkg::ST_FETCH;
         end else if (modrm[7:6] != x86ss_pkg::MOD_REG) begin
            dec.status = x86ss_pkg::ST_NOTIMPL;
         end else if (opc == x86ss_pkg::OPC_XOR) begin
            dec.kind = x86ss_pkg::KIND_XOR;
            dec.len  = off2[3:0];
         end else if (opc == x86ss_pkg::OPC_AND) begin
            dec.kind = x86ss_pkg::KIND_AND;
            dec.len  = 4'({1'b0, off} + 5'd3);
         end else begin
            dec.kind = x86ss_pkg::KIND_MOV;
            dec.len  = off2[3:0];
         end
      end else if (opc[7:3] == x86ss_pkg::OPC_POP[7:3]) begin
         dec.rmf = {rex[0], opc[2:0]};
         if (!stack_ok) begin
            dec.status = x86ss_pkg::ST_STACK;
         end else begin
            dec.kind = x86ss_pkg::KIND_POP;
            dec.len  = off1[3:0];
         end
      end else begin
         dec.status = x86ss_pkg::ST_UNDEC;
      end
   end

endmodule

// ----- src/x86_64_subset_decode_execute_top.sv -----
`timescale 1ns / 1ps
// Top level: x86-64 subset decode/execute with a memory-based register file.
// Depends on x86ss_pkg, x86ss_decode and the assertion macro header.
//
// Requests are accepted one per cycle while not stalled; each gives one
// response. Each is decoded and the register file (a 16x64 synchronous
// memory, two read ports, one write port) is read at acceptance; in the
// next cycle the operands arrive and the result is computed, then written
// back and the response registered once the response register is free. A
// write from the item just ahead is forwarded into the following item's
// operands. RSP lives in its own register because POP updates it together
// with a second register. RIP and flags are registers. The response
// register lets a new request enter while a finished response waits.

`include "x86_64_subset_decode_execute_top_assert.svh"

module x86_64_subset_decode_execute_top #(
   parameter int FETCH_WINDOW_BYTES = x86ss_pkg::FetchWindowBytes
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // reg_select, write_value, fetch_bytes, fetch_count, stack_word, stack_ok
   input  logic [x86ss_pkg::ReqDataW-1:0]  req_tdata,
   // command
   input  logic [x86ss_pkg::ReqUserW-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, instr_kind, instr_length, next_rip, read_value, stack_used
   output logic [x86ss_pkg::RspDataW-1:0]  rsp_tdata
);

   typedef struct packed {
      x86ss_pkg::cmd_type cmd;
      logic [4:0]         sel;
      logic [63:0]        wval;
      logic [63:0]        stack_word;
      logic [3:0]         ra;
      x86ss_pkg::dec_type dec;
   } stage_type;

   typedef struct packed {
      logic [4:0]            pad;
      logic                  stack_used;
      logic [63:0]           read_value;
      logic [63:0]           next_rip;
      logic [3:0]            len;
      x86ss_pkg::kind_type   kind;
      x86ss_pkg::status_type status;
   } out_type;

   // request fields
   x86ss_pkg::cmd_type req_cmd;
   logic [4:0]         req_sel;
   logic [63:0]        req_wval;
   logic [63:0]        req_fetch;
   logic [3:0]         req_fcnt;
   logic [63:0]        req_stack;
   logic               req_sok;
   logic               req_fire;
   x86ss_pkg::dec_type req_dec;
   logic [3:0]         rd_a;

   assign req_cmd   = x86ss_pkg::cmd_type'(req_tuser);
   assign req_sel   = req_tdata[4:0];
   assign req_wval  = req_tdata[68:5];
   assign req_fetch = req_tdata[132:69];
   assign req_fcnt  = req_tdata[136:133];
   assign req_stack = req_tdata[200:137];
   assign req_sok   = req_tdata[201];

   x86ss_decode #(
      .FETCH_WINDOW_BYTES (FETCH_WINDOW_BYTES)
   ) u_decode (
      .fetch_bytes (req_fetch),
      .fetch_count (req_fcnt),
      .stack_ok    (req_sok),
      .dec         (req_dec)
   );

   assign rd_a = (req_cmd == x86ss_pkg::CMD_EXEC) ? req_dec.rmf : req_sel[3:0];

   // pipeline control
   logic      s1_valid_ff;
   stage_type s1_ff;
   logic      s1_fire;
   logic      out_valid_ff;
   out_type   out_ff;

   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // register file memory
   logic [63:0] mem [16];
   logic [63:0] mem_a_q;
   logic [63:0] mem_b_q;
   logic        mem_we;
   logic [15:0] vld_ff;
   logic        fwd_vld_ff;
   logic [3:0]  fwd_idx_ff;
   logic [63:0] fwd_data_ff;

   // architectural registers
   logic [63:0] sp_ff, sp_in;
   logic [63:0] rip_ff, rip_in;
   logic [4:0]  flags_ff, flags_in;

   // execute stage
   logic [63:0] a_val, b_val;
   logic [63:0] mask, res, merged;
   logic        sign;
   logic        gpr_we;
   logic [63:0] gpr_wd;
   logic [63:0] read_val;
   logic        exec_ok;
   out_type     out_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_ff.ra] <= gpr_wd;
      end
      if (req_fire) begin
         mem_a_q <= mem[rd_a];
         mem_b_q <= mem[req_dec.regf];
      end
   end

   always_comb begin
      // RSP from its register; forward the write that coincided with the read
      if (s1_ff.ra == x86ss_pkg::RSP_IDX) begin
         a_val = sp_ff;
      end else if (fwd_vld_ff && fwd_idx_ff == s1_ff.ra) begin
         a_val = fwd_data_ff;
      end else begin
         a_val = vld_ff[s1_ff.ra] ? mem_a_q : 64'd0;
      end
      if (s1_ff.dec.regf == x86ss_pkg::RSP_IDX) begin
         b_val = sp_ff;
      end else if (fwd_vld_ff && fwd_idx_ff == s1_ff.dec.regf) begin
         b_val = fwd_data_ff;
      end else begin
         b_val = vld_ff[s1_ff.dec.regf] ? mem_b_q : 64'd0;
      end

      case (s1_ff.dec.size)
         x86ss_pkg::OPS_64: mask = {64{1'b1}};
         x86ss_pkg::OPS_16: mask = 64'h0000_0000_0000_ffff;
         default:           mask = 64'h0000_0000_ffff_ffff;
      endcase
      if (s1_ff.dec.kind == x86ss_pkg::KIND_AND) begin
         res = a_val & {{56{s1_ff.dec.imm[7]}}, s1_ff.dec.imm} & mask;
      end else begin
         res = (a_val ^ b_val) & mask;
      end
      merged = (s1_ff.dec.size == x86ss_pkg::OPS_16) ? {a_val[63:16], res[15:0]} : res;
      case (s1_ff.dec.size)
         x86ss_pkg::OPS_64: sign = res[63];
         x86ss_pkg::OPS_16: sign = res[15];
         default:           sign = res[31];
      endcase

      exec_ok  = (s1_ff.cmd == x86ss_pkg::CMD_EXEC) && (s1_ff.dec.status == x86ss_pkg::ST_OK);
      gpr_we   = 1'b0;
      gpr_wd   = s1_ff.wval;
      sp_in    = sp_ff;
      rip_in   = rip_ff;
      flags_in = flags_ff;
      read_val = 64'd0;

      case (s1_ff.cmd)
         x86ss_pkg::CMD_EXEC: begin
            if (exec_ok) begin
               rip_in = rip_ff + 64'(s1_ff.dec.len);
               case (s1_ff.dec.kind)
                  x86ss_pkg::KIND_XOR, x86ss_pkg::KIND_AND: begin
                     gpr_we   = 1'b1;
                     gpr_wd   = merged;
                     // OF, SF, ZF, PF, CF
                     flags_in = {1'b0, sign, (res == 64'd0), ~^res[7:0], 1'b0};
                  end
                  x86ss_pkg::KIND_MOV: begin
                     gpr_we = 1'b1;
                     gpr_wd = b_val;
                  end
                  x86ss_pkg::KIND_POP: begin
                     // POP RSP ends with the popped word in RSP
                     if (s1_ff.ra == x86ss_pkg::RSP_IDX) begin
                        sp_in = s1_ff.stack_word;
                     end else begin
                        sp_in  = sp_ff + 64'd8;
                        gpr_we = 1'b1;
                        gpr_wd = s1_ff.stack_word;
                     end
                  end
                  default: ;
               endcase
            end
         end
         x86ss_pkg::CMD_WRITE: begin
            if (s1_ff.sel < x86ss_pkg::SEL_RIP) begin
               gpr_we = 1'b1;
            end else if (s1_ff.sel == x86ss_pkg::SEL_RIP) begin
               rip_in = s1_ff.wval;
            end else if (s1_ff.sel == x86ss_pkg::SEL_FLAGS) begin
               flags_in = s1_ff.wval[4:0];
            end
         end
         x86ss_pkg::CMD_READ: begin
            if (s1_ff.sel < x86ss_pkg::SEL_RIP) begin
               read_val = a_val;
            end else if (s1_ff.sel == x86ss_pkg::SEL_RIP) begin
               read_val = rip_ff;
            end else if (s1_ff.sel == x86ss_pkg::SEL_FLAGS) begin
               read_val = {59'd0, flags_ff};
            end
         end
         default: ;
      endcase

      if (gpr_we && s1_ff.ra == x86ss_pkg::RSP_IDX) begin
         sp_in = gpr_wd;
      end

      out_in.pad        = 5'd0;
      out_in.stack_used = exec_ok && (s1_ff.dec.kind == x86ss_pkg::KIND_POP);
      out_in.read_value = read_val;
      out_in.next_rip   = rip_in;
      out_in.len        = exec_ok ? s1_ff.dec.len : 4'd0;
      out_in.kind       = exec_ok ? s1_ff.dec.kind : x86ss_pkg::KIND_NONE;
      out_in.status     = (s1_ff.cmd == x86ss_pkg::CMD_EXEC) ? s1_ff.dec.status
                                                             : x86ss_pkg::ST_OK;
   end

   assign mem_we = s1_fire && gpr_we && (s1_ff.ra != x86ss_pkg::RSP_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         vld_ff       <= '0;
         fwd_vld_ff   <= 1'b0;
         sp_ff        <= 64'd0;
         rip_ff       <= 64'd0;
         flags_ff     <= 5'd0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            out_valid_ff <= 1'b1;
            fwd_vld_ff   <= mem_we;
            sp_ff        <= sp_in;
            rip_ff       <= rip_in;
            flags_ff     <= flags_in;
            if (mem_we) begin
               vld_ff[s1_ff.ra] <= 1'b1;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.cmd        <= req_cmd;
         s1_ff.sel        <= req_sel;
         s1_ff.wval       <= req_wval;
         s1_ff.stack_word <= req_stack;
         s1_ff.ra         <= rd_a;
         s1_ff.dec        <= req_dec;
      end
      if (s1_fire) begin
         out_ff      <= out_in;
         fwd_idx_ff  <= s1_ff.ra;
         fwd_data_ff <= gpr_wd;
      end
   end

   `X86SS_ASSERT_NOW(a_fail_clean, clock, reset, out_valid_ff && out_ff.status != x86ss_pkg::ST_OK, out_ff.kind == x86ss_pkg::KIND_NONE && out_ff.len == 4'd0 && !out_ff.stack_used, "failed request reports decode fields")
   `X86SS_ASSERT_NOW(a_pop_stack, clock, reset, out_valid_ff && out_ff.stack_used, out_ff.kind == x86ss_pkg::KIND_POP, "stack word used by non-POP")
   `X86SS_ASSERT_NEXT(a_hold_operands, clock, reset, s1_valid_ff && !s1_fire, $stable(mem_a_q) && $stable(mem_b_q), "operand read data changed while stalled")
   `X86SS_ASSERT_NEXT(a_accept_stage, clock, reset, req_fire, s1_valid_ff, "accepted request lost before execute")

endmodule
